>>> design/foc_ipc_pkg.sv
package foc_ipc_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CW                = 34;
  localparam int DIV_BITS          = 16;
  localparam int PHASES            = 3;

  localparam logic [1:0] REG_VLIMIT = 2'd0;
  localparam logic [1:0] REG_SUPPLY = 2'd1;

  localparam logic [14:0] VLIMIT_RST = 15'd3072;
  localparam logic [14:0] SUPPLY_RST = 15'd6144;

  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [17:0]   HALF_SQRT3   = 18'sd56756;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
    logic signed [15:0]   uq;
  } cordic_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [15:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [PHASES-1:0]  lo;
    logic [PHASES-1:0]  hi;
  } side_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // saturate a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
    logic signed [15:0] r;
    if (v > 49'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -49'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = signed'(v[15:0]);
    end
    return r;
  endfunction

endpackage

>>> design/foc_ipc_cordic_cell.sv
module foc_ipc_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  foc_ipc_pkg::cordic_t cell_i,
  output logic                 valid_o,
  output foc_ipc_pkg::cordic_t cell_o
);
  import foc_ipc_pkg::*;

  logic signed [CW-1:0] dx, dy, at;
  cordic_t              cell_d, cell_q;
  logic                 valid_q;

  // one micro-rotation, direction from the residual angle sign
  always_comb begin
    dx     = cell_i.y >>> STAGE;
    dy     = cell_i.x >>> STAGE;
    at     = signed'({2'b00, atan_turns(STAGE)});
    cell_d = cell_i;
    if (!cell_i.z[CW-1]) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - at;
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + at;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

>>> design/foc_ipc_div_cell.sv
module foc_ipc_div_cell #(
  parameter int BIT = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [14:0]            sup_i,
  input  foc_ipc_pkg::div_lane_t lane_i [foc_ipc_pkg::PHASES],
  output logic                   valid_o,
  output foc_ipc_pkg::div_lane_t lane_o [foc_ipc_pkg::PHASES]
);
  import foc_ipc_pkg::*;

  logic [31:0] cmp;
  div_lane_t   lane_d [PHASES];
  div_lane_t   lane_q [PHASES];
  logic        valid_q;

  // one restoring quotient bit per phase lane
  always_comb begin
    cmp = {17'd0, sup_i} << BIT;
    for (int p = 0; p < PHASES; p++) begin
      lane_d[p] = lane_i[p];
      if (lane_i[p].rem >= cmp) begin
        lane_d[p].rem      = lane_i[p].rem - cmp;
        lane_d[p].quo[BIT] = 1'b1;
      end
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

>>> design/foc_inverse_park_clarke_duty_unit.sv
// pipeline from request to done_o: input register, the CORDIC cell row, product, alpha/beta,
//   phase voltage and numerator registers, the 16 divider cells, then the output register
// throughput: one request per cycle, busy stays low; done_o cannot be stalled
// reset: rst_ni asynchronous active low clears all valid flags and loads
//   the command limit with 3072 and the supply register with 6144
module foc_inverse_park_clarke_duty_unit #(
  parameter int ANGLE_BITS    = foc_ipc_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = foc_ipc_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quad_voltage_i,
  input  logic [15:0]        elec_angle_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [15:0] alpha_voltage_o,
  output logic signed [15:0] beta_voltage_o,
  output logic [15:0]        duty_a_o,
  output logic [15:0]        duty_b_o,
  output logic [15:0]        duty_c_o,
  output logic               duty_clamped_o
);
  import foc_ipc_pkg::*;

  localparam int ANG_DROP = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
  localparam logic [15:0] ANG_MASK = 16'hFFFF << ANG_DROP;
  localparam int LAT = CORDIC_STAGES + 22;

  logic        accept;
  logic [14:0] vlimit_q, supply_q, sup_eff;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign sup_eff     = (supply_q == 15'd0) ? 15'd1 : supply_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlimit_q <= VLIMIT_RST;
      supply_q <= SUPPLY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VLIMIT: vlimit_q <= cfg_data_i;
        REG_SUPPLY: supply_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage: clamp command, fold angle into right half plane
  logic signed [16:0] lim_p, uq_w;
  logic signed [15:0] uq_c;
  logic [15:0]        ang, ph;
  logic               flip;
  cordic_t            s0_d, s0_q;
  logic               v_s0_q;

  always_comb begin
    lim_p = signed'({2'b00, vlimit_q});
    uq_w  = 17'(quad_voltage_i);
    if (uq_w > lim_p) begin
      uq_w = lim_p;
    end else if (uq_w < -lim_p) begin
      uq_w = -lim_p;
    end
    uq_c   = signed'(uq_w[15:0]);
    ang    = elec_angle_i & ANG_MASK;
    flip   = ang[15] ^ ang[14];
    ph     = flip ? (ang ^ 16'h8000) : ang;
    s0_d.x = CORDIC_START;
    s0_d.y = '0;
    s0_d.z = signed'({{2{ph[15]}}, ph, 16'h0000});
    s0_d.flip = flip;
    s0_d.uq   = uq_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s0_q <= 1'b0;
    end else begin
      v_s0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
  end

  // cordic cell row
  cordic_t cc [CORDIC_STAGES+1];
  logic    cv [CORDIC_STAGES+1];

  assign cc[0] = s0_q;
  assign cv[0] = v_s0_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    foc_ipc_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cv[g]),
      .cell_i (cc[g]),
      .valid_o(cv[g+1]),
      .cell_o (cc[g+1])
    );
  end

  // inverse park products
  logic signed [CW-1:0] sn_w, cs_w;
  logic signed [31:0]   sn, cs;
  logic signed [47:0]   ps_q, pc_q;
  logic                 v_m_q;

  always_comb begin
    sn_w = cc[CORDIC_STAGES].flip ? -cc[CORDIC_STAGES].y : cc[CORDIC_STAGES].y;
    cs_w = cc[CORDIC_STAGES].flip ? -cc[CORDIC_STAGES].x : cc[CORDIC_STAGES].x;
    sn   = signed'(sn_w[31:0]);
    cs   = signed'(cs_w[31:0]);
  end

  always_ff @(posedge clk_i) begin
    ps_q <= cc[CORDIC_STAGES].uq * sn;
    pc_q <= cc[CORDIC_STAGES].uq * cs;
  end

  // round and saturate alpha and beta
  logic signed [48:0] na, nb;
  logic signed [15:0] alpha_q, beta_q;
  logic               v_ab_q;

  always_comb begin
    na = (-49'(ps_q) + 49'sd536870912) >>> 30;
    nb = (49'(pc_q) + 49'sd536870912) >>> 30;
  end

  always_ff @(posedge clk_i) begin
    alpha_q <= sat16(na);
    beta_q  <= sat16(nb);
  end

  // inverse clarke into Q19.16 phase voltages
  logic signed [34:0] va_q, vb_q, vc_q, ah, bp;
  logic signed [33:0] bprod;
  logic signed [15:0] alpha_v_q, beta_v_q;
  logic               v_v_q;

  always_comb begin
    bprod = beta_q * HALF_SQRT3;
    bp    = 35'(bprod);
    ah    = signed'({{4{alpha_q[15]}}, alpha_q, 15'h0000});
  end

  always_ff @(posedge clk_i) begin
    va_q      <= signed'({{3{alpha_q[15]}}, alpha_q, 16'h0000});
    vb_q      <= bp - ah;
    vc_q      <= -ah - bp;
    alpha_v_q <= alpha_q;
    beta_v_q  <= beta_q;
  end

  // duty numerator and range flags
  logic signed [34:0] rv [PHASES];
  logic signed [34:0] bias;
  div_lane_t          dl_d [PHASES];
  side_t              sd_d;
  div_lane_t          dc [DIV_BITS+1][PHASES];
  logic               dv [DIV_BITS+1];
  side_t              sd [DIV_BITS+1];
  logic               v_d_q;

  always_comb begin
    bias  = signed'({5'd0, sup_eff, 15'h0000}) + signed'({20'd0, sup_eff >> 1});
    rv[0] = va_q + bias;
    rv[1] = vb_q + bias;
    rv[2] = vc_q + bias;
    sd_d.alpha = alpha_v_q;
    sd_d.beta  = beta_v_q;
    for (int p = 0; p < PHASES; p++) begin
      sd_d.lo[p]  = rv[p][34];
      sd_d.hi[p]  = !rv[p][34] && (rv[p][34:16] >= {4'd0, sup_eff});
      dl_d[p].rem = rv[p][31:0];
      dl_d[p].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    dc[0] <= dl_d;
    sd[0] <= sd_d;
  end

  assign dv[0] = v_d_q;

  // divider cell row, one quotient bit per cell from the top
  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    foc_ipc_div_cell #(.BIT(DIV_BITS - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv[g]),
      .sup_i  (sup_eff),
      .lane_i (dc[g]),
      .valid_o(dv[g+1]),
      .lane_o (dc[g+1])
    );

    always_ff @(posedge clk_i) begin
      sd[g+1] <= sd[g];
    end
  end

  // valid flags of the arithmetic stages
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_m_q  <= 1'b0;
      v_ab_q <= 1'b0;
      v_v_q  <= 1'b0;
      v_d_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v_m_q  <= cv[CORDIC_STAGES];
      v_ab_q <= v_m_q;
      v_v_q  <= v_ab_q;
      v_d_q  <= v_v_q;
      done_q <= dv[DIV_BITS];
    end
  end

  // output register with saturation
  logic [15:0] duty_q [PHASES];
  logic        clamped_q;
  logic signed [15:0] alpha_o_q, beta_o_q;

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < PHASES; p++) begin
      if (sd[DIV_BITS].lo[p]) begin
        duty_q[p] <= 16'h0000;
      end else if (sd[DIV_BITS].hi[p]) begin
        duty_q[p] <= 16'hFFFF;
      end else begin
        duty_q[p] <= dc[DIV_BITS][p].quo;
      end
    end
    clamped_q <= |(sd[DIV_BITS].lo | sd[DIV_BITS].hi);
    alpha_o_q <= sd[DIV_BITS].alpha;
    beta_o_q  <= sd[DIV_BITS].beta;
  end

  assign done_o          = done_q;
  assign alpha_voltage_o = alpha_o_q;
  assign beta_voltage_o  = beta_o_q;
  assign duty_a_o        = duty_q[0];
  assign duty_b_o        = duty_q[1];
  assign duty_c_o        = duty_q[2];
  assign duty_clamped_o  = clamped_q;

  // every accepted request yields a result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o) else $error("result missing after request");

  // the valid chain never invents a result
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> dv[DIV_BITS] == 1'b0 || $past(dv[DIV_BITS])) else $error("spurious result");

  // a limit write lands in the register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i == REG_VLIMIT) |=> vlimit_q == $past(cfg_data_i))
    else $error("limit write lost");

  // a saturated duty always raises the flag
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv[DIV_BITS] && (sd[DIV_BITS].lo != '0 || sd[DIV_BITS].hi != '0)) |=> duty_clamped_o)
    else $error("clamp flag missing");

endmodule
